// File: hdl/symmetric_group_character_eval_defines.svh
// assertion macros for the symmetric group character evaluator
// used by the top level only; no other dependencies
`ifndef SYMMETRIC_GROUP_CHARACTER_EVAL_DEFINES_SVH
`define SYMMETRIC_GROUP_CHARACTER_EVAL_DEFINES_SVH

// antecedent implies consequent on the same edge
`define SGCE_ASSERT_IMPLY(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent on the next edge
`define SGCE_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

// condition never holds
`define SGCE_ASSERT_NEVER(label, ck, rn, cond, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
    else $error(msg);

`endif

// File: hdl/sgce_pkg.sv
// shared types, constants and state encoding for the character evaluator
// no dependencies
package sgce_pkg;

  localparam int MAX_PARTS_DEF     = 32;
  localparam int BOUNDARY_BITS_DEF = 64;
  localparam int PART_W            = 6;
  localparam int VALUE_W           = 64;
  localparam int STATUS_W          = 2;

  // load command codes
  localparam logic CMD_SHAPE = 1'b0;
  localparam logic CMD_CYCLE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BOUNDARY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TOO_MANY = 2'd2;

  typedef struct packed {
    logic              cmd;
    logic [PART_W-1:0] part;
    logic              last;
  } sgce_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [STATUS_W-1:0]       status;
  } sgce_out_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CHECK,
    ST_B_RD,
    ST_B_USE,
    ST_B_END,
    ST_K_RD,
    ST_K_USE,
    ST_STEP_A,
    ST_STEP_B,
    ST_STEP_C,
    ST_POP_RD,
    ST_POP_USE,
    ST_FINISH
  } sgce_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic build_init;
    logic build_step;
    logic search_init;
    logic sum_one;
    logic load_k;
    logic take_low;
    logic calc_hook;
    logic leaf_add;
    logic push;
    logic pop;
    logic pop_load;
    logic finish;
  } sgce_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic too_many;
    logic build_done;
    logic fits;
    logic no_cycles;
    logic cand_zero;
    logic lvl_zero;
    logic leaf;
    logic out_free;
  } sgce_sts_t;

endpackage

// File: hdl/sgce_ram.sv
// generic single write port ram with registered read
// no dependencies
module sgce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/sgce_dp.sv
// datapath: part stores, boundary builder, search stack, hook unit, accumulator
// depends on sgce_pkg and sgce_ram
module sgce_dp import sgce_pkg::*; #(
  parameter int MAX_PARTS     = MAX_PARTS_DEF,
  parameter int BOUNDARY_BITS = BOUNDARY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  sgce_in_t  in_data,
  input  sgce_cmd_t cmd,
  output sgce_sts_t sts,
  input  logic      out_stall,
  output logic      out_valid,
  output sgce_out_t out_data
);

  localparam int AW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int CW = $clog2(MAX_PARTS + 1);
  localparam int LW = CW + 1;
  localparam int BW = BOUNDARY_BITS;
  localparam int IW = $clog2(BOUNDARY_BITS + 64);
  localparam int SW = 2 * BW + 1;

  // load counters and flags
  logic [CW-1:0] shape_cnt_r, shape_cnt_nxt;
  logic [CW-1:0] cycle_cnt_r, cycle_cnt_nxt;
  logic          too_many_r, too_many_nxt;

  // boundary builder
  logic [CW-1:0]     bcnt_r, bcnt_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [PART_W-1:0] prev_r, prev_nxt;
  logic [BW-1:0]     bnd_r, bnd_nxt;
  logic              fits_r, fits_nxt;

  // top of the search stack
  logic [BW-1:0]     top_b_r, top_b_nxt;
  logic              top_s_r, top_s_nxt;
  logic [BW-1:0]     top_c_r, top_c_nxt;
  logic [PART_W-1:0] top_k_r, top_k_nxt;
  logic [BW-1:0]     low_r, low_nxt;
  logic [BW-1:0]     nb_r, nb_nxt;
  logic              ns_r, ns_nxt;
  logic [AW-1:0]     lvl_r, lvl_nxt;
  logic [VALUE_W-1:0] sum_r, sum_nxt;

  // result register
  logic      out_valid_r, out_valid_nxt;
  sgce_out_t out_data_r, out_data_nxt;

  // memory ports
  logic              shape_we, cycle_we, stack_we;
  logic [PART_W-1:0] shape_rdata, cycle_rdata;
  logic [SW-1:0]     stack_rdata;
  logic [CW-1:0]     bcnt_dec;

  // combinational helpers
  logic [IW-1:0]       idx_t;
  logic [PART_W-1:0]   prev_t;
  logic                over;
  logic [BW-1:0]       c_dec, hi, inner;
  logic [STATUS_W-1:0] res_status;

  assign shape_we = cmd.load && (in_data.cmd == CMD_SHAPE) && (shape_cnt_r < CW'(MAX_PARTS));
  assign cycle_we = cmd.load && (in_data.cmd == CMD_CYCLE) && (cycle_cnt_r < CW'(MAX_PARTS));
  assign stack_we = cmd.push;
  assign bcnt_dec = bcnt_r - CW'(1);

  sgce_ram #(.WIDTH(PART_W), .DEPTH(MAX_PARTS)) u_shape_ram (
    .clk   (clk),
    .we    (shape_we),
    .waddr (shape_cnt_r[AW-1:0]),
    .wdata (in_data.part),
    .raddr (bcnt_dec[AW-1:0]),
    .rdata (shape_rdata)
  );

  sgce_ram #(.WIDTH(PART_W), .DEPTH(MAX_PARTS)) u_cycle_ram (
    .clk   (clk),
    .we    (cycle_we),
    .waddr (cycle_cnt_r[AW-1:0]),
    .wdata (in_data.part),
    .raddr (lvl_r),
    .rdata (cycle_rdata)
  );

  // boundary word, sign and remaining hooks per level
  sgce_ram #(.WIDTH(SW), .DEPTH(MAX_PARTS)) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (lvl_r),
    .wdata ({top_b_r, top_s_r, top_c_r}),
    .raddr (lvl_r),
    .rdata (stack_rdata)
  );

  // one boundary walk step: climb to the new part, then a vertical step
  always_comb begin
    if (shape_rdata > prev_r) begin
      idx_t  = idx_r + IW'(shape_rdata - prev_r);
      prev_t = shape_rdata;
    end else begin
      idx_t  = idx_r;
      prev_t = prev_r;
    end
    over = idx_t >= IW'(BW);
  end

  // hook unit pieces
  assign c_dec = top_c_r - BW'(1);
  assign hi    = low_r << top_k_r;
  assign inner = hi - (low_r << 1);

  assign res_status = too_many_r ? STATUS_TOO_MANY :
                      (fits_r ? STATUS_OK : STATUS_BOUNDARY);

  // next-state logic of the datapath registers
  always_comb begin
    shape_cnt_nxt = shape_cnt_r;
    cycle_cnt_nxt = cycle_cnt_r;
    too_many_nxt  = too_many_r;
    bcnt_nxt      = bcnt_r;
    idx_nxt       = idx_r;
    prev_nxt      = prev_r;
    bnd_nxt       = bnd_r;
    fits_nxt      = fits_r;
    top_b_nxt     = top_b_r;
    top_s_nxt     = top_s_r;
    top_c_nxt     = top_c_r;
    top_k_nxt     = top_k_r;
    low_nxt       = low_r;
    nb_nxt        = nb_r;
    ns_nxt        = ns_r;
    lvl_nxt       = lvl_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    // appends; a full store drops the part
    if (cmd.load) begin
      if (shape_we) begin
        shape_cnt_nxt = shape_cnt_r + CW'(1);
      end else if (cycle_we) begin
        cycle_cnt_nxt = cycle_cnt_r + CW'(1);
      end else begin
        too_many_nxt = 1'b1;
      end
    end

    if (cmd.build_init) begin
      bcnt_nxt = shape_cnt_r;
      idx_nxt  = '0;
      prev_nxt = '0;
      bnd_nxt  = '0;
      fits_nxt = 1'b1;
    end

    if (cmd.build_step) begin
      bcnt_nxt = bcnt_dec;
      if (fits_r) begin
        prev_nxt = prev_t;
        idx_nxt  = idx_t + IW'(1);
        if (over) begin
          fits_nxt = 1'b0;
        end else begin
          bnd_nxt = bnd_r | (BW'(1) << idx_t);
        end
      end
    end

    if (cmd.search_init) begin
      top_b_nxt = bnd_r;
      top_s_nxt = 1'b0;
      lvl_nxt   = '0;
      sum_nxt   = '0;
    end

    if (cmd.sum_one) begin
      sum_nxt = VALUE_W'(1);
    end

    // hooks of length k: a 0 with a 1 k places higher
    if (cmd.load_k) begin
      top_k_nxt = cycle_rdata;
      top_c_nxt = ~top_b_r & (top_b_r >> cycle_rdata);
    end

    // take the lowest hook off the candidate set
    if (cmd.take_low) begin
      top_c_nxt = top_c_r & c_dec;
      low_nxt   = top_c_r & ~c_dec;
    end

    // remove the hook; odd height flips the sign
    if (cmd.calc_hook) begin
      nb_nxt = top_b_r ^ low_r ^ hi;
      ns_nxt = top_s_r ^ (^(top_b_r & inner));
    end

    if (cmd.leaf_add) begin
      sum_nxt = sum_r + (ns_r ? {VALUE_W{1'b1}} : VALUE_W'(1));
    end

    if (cmd.push) begin
      top_b_nxt = nb_r;
      top_s_nxt = ns_r;
      lvl_nxt   = lvl_r + AW'(1);
    end

    if (cmd.pop) begin
      lvl_nxt = lvl_r - AW'(1);
    end

    if (cmd.pop_load) begin
      top_b_nxt = stack_rdata[SW-1 -: BW];
      top_s_nxt = stack_rdata[BW];
      top_c_nxt = stack_rdata[BW-1:0];
      top_k_nxt = cycle_rdata;
    end

    // hand the result over and clear the loads
    if (cmd.finish) begin
      out_valid_nxt       = 1'b1;
      out_data_nxt.status = res_status;
      out_data_nxt.value  = (res_status == STATUS_OK) ? $signed(sum_r) : '0;
      shape_cnt_nxt       = '0;
      cycle_cnt_nxt       = '0;
      too_many_nxt        = 1'b0;
      fits_nxt            = 1'b1;
      lvl_nxt             = '0;
      sum_nxt             = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_cnt_r <= '0;
      cycle_cnt_r <= '0;
      too_many_r  <= 1'b0;
      fits_r      <= 1'b1;
      lvl_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      shape_cnt_r <= shape_cnt_nxt;
      cycle_cnt_r <= cycle_cnt_nxt;
      too_many_r  <= too_many_nxt;
      fits_r      <= fits_nxt;
      lvl_r       <= lvl_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    bcnt_r     <= bcnt_nxt;
    idx_r      <= idx_nxt;
    prev_r     <= prev_nxt;
    bnd_r      <= bnd_nxt;
    top_b_r    <= top_b_nxt;
    top_s_r    <= top_s_nxt;
    top_c_r    <= top_c_nxt;
    top_k_r    <= top_k_nxt;
    low_r      <= low_nxt;
    nb_r       <= nb_nxt;
    ns_r       <= ns_nxt;
    out_data_r <= out_data_nxt;
  end

  // status to the controller
  always_comb begin
    sts.too_many   = too_many_r;
    sts.build_done = (bcnt_r == '0);
    sts.fits       = fits_r;
    sts.no_cycles  = (cycle_cnt_r == '0);
    sts.cand_zero  = (top_c_r == '0);
    sts.lvl_zero   = (lvl_r == '0);
    sts.leaf       = (LW'(lvl_r) + LW'(1)) >= LW'(cycle_cnt_r);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/sgce_ctrl.sv
// controller: load, boundary build, depth-first hook search, result handoff
// depends on sgce_pkg
module sgce_ctrl import sgce_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last,
  input  sgce_sts_t sts,
  output sgce_cmd_t cmd,
  output logic      in_stall
);

  sgce_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid && in_last) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        state_nxt = sts.too_many ? ST_FINISH : ST_B_RD;
      end
      ST_B_RD: begin
        state_nxt = sts.build_done ? ST_B_END : ST_B_USE;
      end
      ST_B_USE: begin
        state_nxt = ST_B_RD;
      end
      ST_B_END: begin
        state_nxt = (!sts.fits || sts.no_cycles) ? ST_FINISH : ST_K_RD;
      end
      ST_K_RD: begin
        state_nxt = ST_K_USE;
      end
      ST_K_USE: begin
        state_nxt = ST_STEP_A;
      end
      ST_STEP_A: begin
        if (!sts.cand_zero) begin
          state_nxt = ST_STEP_B;
        end else begin
          state_nxt = sts.lvl_zero ? ST_FINISH : ST_POP_RD;
        end
      end
      ST_STEP_B: begin
        state_nxt = ST_STEP_C;
      end
      ST_STEP_C: begin
        state_nxt = sts.leaf ? ST_STEP_A : ST_K_RD;
      end
      ST_POP_RD: begin
        state_nxt = ST_POP_USE;
      end
      ST_POP_USE: begin
        state_nxt = ST_STEP_A;
      end
      ST_FINISH: begin
        if (sts.out_free) state_nxt = ST_LOAD;
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_LOAD: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_CHECK: begin
        cmd.build_init = !sts.too_many;
      end
      ST_B_USE: begin
        cmd.build_step = 1'b1;
      end
      ST_B_END: begin
        cmd.sum_one     = sts.fits && sts.no_cycles;
        cmd.search_init = sts.fits && !sts.no_cycles;
      end
      ST_K_USE: begin
        cmd.load_k = 1'b1;
      end
      ST_STEP_A: begin
        cmd.take_low = !sts.cand_zero;
        cmd.pop      = sts.cand_zero && !sts.lvl_zero;
      end
      ST_STEP_B: begin
        cmd.calc_hook = 1'b1;
      end
      ST_STEP_C: begin
        cmd.leaf_add = sts.leaf;
        cmd.push     = !sts.leaf;
      end
      ST_POP_USE: begin
        cmd.pop_load = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: hdl/symmetric_group_character_eval.sv
// load items: one per cycle while idle; in_stall is high from the last item until handoff
// after the last item: the boundary is built from the shape parts, then the sequencer
// walks one hook at a time through the stack memory, entering levels and backtracking;
// an overflow skips to the handoff, which waits while the previous result is pending
// reset: synchronous active low, clears counts, flags, level, sum and the controller;
// part and stack memories are not cleared and need no clearing pass
module symmetric_group_character_eval import sgce_pkg::*; #(
  parameter int MAX_PARTS     = MAX_PARTS_DEF,
  parameter int BOUNDARY_BITS = BOUNDARY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  sgce_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output sgce_out_t out_data
);

`include "symmetric_group_character_eval_defines.svh"

  sgce_cmd_t cmd;
  sgce_sts_t sts;

  // sequencer
  sgce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // storage and arithmetic
  sgce_dp #(
    .MAX_PARTS     (MAX_PARTS),
    .BOUNDARY_BITS (BOUNDARY_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // result only written when the output register can take it
  `SGCE_ASSERT_IMPLY(a_finish_free, clk, rst_n, cmd.finish, sts.out_free, "result overwrite")
  // no push past the final cycle part, no pop below the root
  `SGCE_ASSERT_IMPLY(a_push_depth, clk, rst_n, cmd.push, !sts.leaf, "push at leaf level")
  `SGCE_ASSERT_IMPLY(a_pop_root, clk, rst_n, cmd.pop, !sts.lvl_zero, "pop at root level")
  // a push always leaves the search below the root
  `SGCE_ASSERT_NEXT(a_push_lvl, clk, rst_n, cmd.push, !sts.lvl_zero, "level did not advance")
  // loads and result handoff never share a cycle
  `SGCE_ASSERT_NEVER(a_load_finish, clk, rst_n, (in_valid && !in_stall) && cmd.finish,
                     "transaction accepted during handoff")

endmodule
